// File: hw/rtl/page_frame_bitmap_allocator_assert.svh
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define PFBA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/pfba_pkg.sv
package pfba_pkg;

  localparam int MAX_FRAMES = 65536;
  localparam int PAGE_SHIFT = 12;

  localparam int MAP_WORDS  = MAX_FRAMES / 8;
  localparam int MAP_FRAMES = MAP_WORDS * 8;
  localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LIM_BITS   = $clog2(MAP_FRAMES + 1);
  localparam int LIM_W      = (LIM_BITS > 17) ? LIM_BITS : 17;

  localparam int ADDR_W = 32;
  localparam int REG_W  = 17;

  localparam logic [7:0] FULL_WORD = 8'hFF;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_MARK  = 2'd2;

  localparam logic REG_USABLE   = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_OUT_OF_MAP = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_addr;
    status_e           status;
  } pfba_rsp_t;

  // Index of the lowest set bit of an 8-bit word.
  function automatic logic [2:0] lowest_bit(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/pfba_ram.sv
module pfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/pfba_core.sv
module pfba_core import pfba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [ADDR_W-1:0] phys_addr_i,
  input  logic [REG_W-1:0]  usable_i,
  input  logic [REG_W-1:0]  reserved_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output pfba_rsp_t         rsp_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_RESP
  } state_e;

  state_e             state_q, state_d;
  logic [WORD_AW-1:0] clr_q, clr_d;
  logic [WORD_AW-1:0] chk_q, chk_d;
  logic [WORD_AW-1:0] last_q, last_d;
  logic               first_q, first_d;
  logic [7:0]         lomask_q, lomask_d;
  logic               set_q, set_d;
  logic [2:0]         bit_q, bit_d;
  pfba_rsp_t          rsp_q, rsp_d;

  logic               ram_we;
  logic [WORD_AW-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [WORD_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;

  logic [LIM_W-1:0]   lim_raw;
  logic [LIM_W-1:0]   lim_c;
  logic [LIM_W-1:0]   res_c;
  logic [ADDR_W-1:0]  frame_full;
  logic [7:0]         avail;
  logic [2:0]         avail_bit;

  pfba_ram #(
    .WIDTH(8),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = rsp_q;

  // The usable limit is rounded down to whole map words and capped at the map size.
  assign lim_raw    = LIM_W'({usable_i[REG_W-1:3], 3'b000});
  assign lim_c      = (lim_raw > LIM_W'(MAP_FRAMES)) ? LIM_W'(MAP_FRAMES) : lim_raw;
  assign res_c      = LIM_W'(reserved_i);
  assign frame_full = phys_addr_i >> PAGE_SHIFT;

  assign avail     = ~ram_rdata & (first_q ? lomask_q : FULL_WORD);
  assign avail_bit = lowest_bit(avail);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    chk_d     = chk_q;
    last_d    = last_q;
    first_d   = first_q;
    lomask_d  = lomask_q;
    set_d     = set_q;
    bit_d     = bit_q;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = chk_q;
    ram_wdata = 8'h00;
    ram_re    = 1'b0;
    ram_raddr = chk_q + WORD_AW'(1);

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + WORD_AW'(1);
        if (clr_q == WORD_AW'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          rsp_d.frame_addr = '0;
          rsp_d.status     = ST_DONE;
          case (mode_i)
            MODE_ALLOC: begin
              if (res_c >= lim_c) begin
                rsp_d.status = ST_NO_FREE;
                state_d      = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = res_c[3 +: WORD_AW];
                chk_d     = res_c[3 +: WORD_AW];
                last_d    = WORD_AW'((lim_c >> 3) - LIM_W'(1));
                lomask_d  = FULL_WORD << res_c[2:0];
                first_d   = 1'b1;
                state_d   = S_SCAN;
              end
            end
            MODE_FREE, MODE_MARK: begin
              if (33'(frame_full) >= 33'(MAP_FRAMES)) begin
                rsp_d.status = ST_OUT_OF_MAP;
                state_d      = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = frame_full[3 +: WORD_AW];
                chk_d     = frame_full[3 +: WORD_AW];
                bit_d     = frame_full[2:0];
                set_d     = (mode_i == MODE_MARK);
                state_d   = S_UPDATE;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Read data belongs to word chk_q; the next word is fetched meanwhile.
        ram_re  = (chk_q != last_q);
        first_d = 1'b0;
        if (avail != 8'h00) begin
          ram_we           = 1'b1;
          ram_wdata        = ram_rdata | (8'h01 << avail_bit);
          rsp_d.frame_addr = ADDR_W'({chk_q, avail_bit}) << PAGE_SHIFT;
          rsp_d.status     = ST_DONE;
          state_d          = S_RESP;
        end else if (chk_q == last_q) begin
          rsp_d.status = ST_NO_FREE;
          state_d      = S_RESP;
        end else begin
          chk_d = chk_q + WORD_AW'(1);
        end
      end
      S_UPDATE: begin
        ram_we    = 1'b1;
        ram_wdata = set_q ? (ram_rdata | (8'h01 << bit_q))
                          : (ram_rdata & ~(8'h01 << bit_q));
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      chk_q    <= '0;
      last_q   <= '0;
      first_q  <= 1'b0;
      lomask_q <= '0;
      set_q    <= 1'b0;
      bit_q    <= '0;
      rsp_q    <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      chk_q    <= chk_d;
      last_q   <= last_d;
      first_q  <= first_d;
      lomask_q <= lomask_d;
      set_q    <= set_d;
      bit_q    <= bit_d;
      rsp_q    <= rsp_d;
    end
  end

`include "page_frame_bitmap_allocator_assert.svh"

  `PFBA_ASSERT(a_accept_leaves_idle, in_valid_i && in_ready_o |=> state_q != S_IDLE, "accepted transaction did not start")
  `PFBA_ASSERT(a_scan_in_range, state_q == S_SCAN |-> chk_q <= last_q, "scan pointer passed the last word")
  `PFBA_ASSERT(a_scan_write_ends, ram_we && state_q == S_SCAN |=> state_q == S_RESP, "allocation write did not end the scan")
  `PFBA_ASSERT(a_alloc_sets_new_bit, ram_we && state_q == S_SCAN |-> ram_wdata != ram_rdata, "allocated frame was already taken")

endmodule

// File: hw/rtl/page_frame_bitmap_allocator.sv
// Free and mark-used read the map word, write it back updated, then pass on their result.
// Allocate reads N map words (1 up to 8192) until it finds a free frame or reaches the limit,
// one word per cycle through the map memory's single read port.
// Requests that need no map access (no range, outside the map, unused mode) go straight to the response.
// One request is in flight at a time; a result waits in an output register.
// After reset the map is cleared word by word while s_axis_tready is low.
module page_frame_bitmap_allocator import pfba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ADDR_W-1:0] s_axis_tdata,  // [31:0] phys_addr
  input  logic [1:0]        s_axis_tuser,  // [1:0] mode
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [ADDR_W-1:0] m_axis_tdata,  // [31:0] frame_addr
  output logic [1:0]        m_axis_tuser,  // [1:0] status
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [REG_W-1:0]  cfg_wdata_i
);

  logic [REG_W-1:0] usable_q;
  logic [REG_W-1:0] reserved_q;
  logic             out_valid_q;
  pfba_rsp_t        out_q;
  logic             rsp_valid;
  logic             rsp_ready;
  pfba_rsp_t        rsp;

  assign rsp_ready = !out_valid_q || m_axis_tready;

  pfba_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tuser),
    .phys_addr_i(s_axis_tdata),
    .usable_i   (usable_q),
    .reserved_i (reserved_q),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q    <= REG_W'(65536);
      reserved_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_USABLE:   usable_q   <= cfg_wdata_i;
          REG_RESERVED: reserved_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (rsp_ready) begin
        out_valid_q <= rsp_valid;
        if (rsp_valid) begin
          out_q <= rsp;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.frame_addr;
  assign m_axis_tuser  = out_q.status;

endmodule
